// File: hw/rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// Keyword token lexer package
// Shared result type, token kind codes, character codes and keyword spelling
// helpers for the keyword token lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

    // Default longest word before the length counter saturates.
    localparam int MAX_WORD_DEF = 254;

    // Depth of the result queue in front of the token channel.
    localparam int QUEUE_DEPTH = 4;

    // Token kind codes.
    localparam logic [3:0] K_EOF     = 4'd0;
    localparam logic [3:0] K_COLON   = 4'd1;
    localparam logic [3:0] K_SEMI    = 4'd2;
    localparam logic [3:0] K_EQ      = 4'd3;
    localparam logic [3:0] K_PLUS    = 4'd4;
    localparam logic [3:0] K_MINUS   = 4'd5;
    localparam logic [3:0] K_LBRACE  = 4'd6;
    localparam logic [3:0] K_RBRACE  = 4'd7;
    localparam logic [3:0] K_LET     = 4'd8;
    localparam logic [3:0] K_RETURN  = 4'd9;
    localparam logic [3:0] K_I32     = 4'd10;
    localparam logic [3:0] K_IDENT   = 4'd11;
    localparam logic [3:0] K_LITERAL = 4'd12;
    localparam logic [3:0] K_UNKNOWN = 4'd13;

    // Character codes the lexer recognises.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_TWO    = 8'h32;

    // One result item on the token channel.
    typedef struct packed {
        logic       is_token;
        logic [3:0] token_kind;
        logic [7:0] text_char;
        logic       word_overflow;
    } kwl_result_t;

    // Up to two results produced by one accepted byte.
    typedef struct packed {
        logic [1:0]  count;
        kwl_result_t first;
        kwl_result_t second;
    } kwl_push_t;

    // Letter of "let" at a given position (positions 0 to 2).
    function automatic logic [7:0] let_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Letter of "return" at a given position (positions 0 to 5).
    function automatic logic [7:0] return_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/kwl_byte_if.sv
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel that carries one source byte or an end mark per
// transfer.
// ----------------------------------------------------------------------------
interface kwl_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink   (input valid, input source_byte, input end_of_input, output ready);

endinterface

// File: hw/rtl/kwl_token_if.sv
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one echoed word character or one
// completed token per transfer.
// ----------------------------------------------------------------------------
interface kwl_token_if;

    logic       valid;
    logic       ready;
    logic       is_token;
    logic [3:0] token_kind;
    logic [7:0] text_char;
    logic       word_overflow;

    modport source (output valid, output is_token, output token_kind, output text_char,
                    output word_overflow, input ready);
    modport sink   (input valid, input is_token, input token_kind, input text_char,
                    input word_overflow, output ready);

endinterface

// File: hw/rtl/keyword_token_lexer_core.sv
// ----------------------------------------------------------------------------
// Keyword token lexer core
// Streaming lexer: one source byte per transfer in, echoed word characters
// and completed tokens out.
//
//   channel    direction  payload
//   byte_ch    in         source_byte, end_of_input
//   token_ch   out        is_token, token_kind, text_char, word_overflow
//
// A byte is lexed in the cycle it is taken; its results are registered into
// a four-entry result queue that drives token_ch.
// Bytes are taken every cycle while the queue has room for two results, so a
// byte that ends a word and also gives its own result takes two transfers on token_ch.
// Reset returns the lexer to idle with no word pending and empties the queue.
// A stall on token_ch fills the queue and then holds byte_ch off.
// ----------------------------------------------------------------------------
module keyword_token_lexer_core #(
    parameter int MAX_WORD = kwl_pkg::MAX_WORD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    kwl_byte_if.sink   byte_ch,
    kwl_token_if.source token_ch
);
    import kwl_pkg::*;

    logic      space;
    logic      accept;
    kwl_push_t push;

    // Byte channel handshake.
    assign byte_ch.ready = space;
    assign accept        = byte_ch.valid && space;

    // Per-byte lexing.
    kwl_scan #(
        .MAX_WORD (MAX_WORD)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .source_byte  (byte_ch.source_byte),
        .end_of_input (byte_ch.end_of_input),
        .push         (push)
    );

    // Result queue to the token channel.
    kwl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space    (space),
        .token_ch (token_ch)
    );

endmodule

// File: hw/rtl/kwl_scan.sv
// ----------------------------------------------------------------------------
// Lexer scan stage
// Holds the word state and combinationally turns each accepted byte into zero,
// one or two results.
// ----------------------------------------------------------------------------
module kwl_scan #(
    parameter int MAX_WORD = kwl_pkg::MAX_WORD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        source_byte,
    input  logic              end_of_input,
    output kwl_pkg::kwl_push_t push
);
    import kwl_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_3   = LEN_W'(3);
    localparam logic [LEN_W-1:0] LEN_6   = LEN_W'(6);

    // Scan phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ALPHA = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             began_reg, began_next;
    logic [2:0]       alive_reg, alive_next;
    logic             ovf_reg, ovf_next;

    logic             is_letter, is_digit, is_space, pending, kw_done, cont;
    logic             fin, tail_valid;
    logic [3:0]       word_kind, punct_kind;
    logic [LEN_W-1:0] b_len;
    logic [2:0]       b_alive, a_alive;
    logic             b_ovf, b_began;
    logic [LEN_W-1:0] a_len;
    logic             a_ovf;
    kwl_result_t      word_res, tail;

    // Character classes.
    always_comb
    begin
        is_letter = source_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_digit  = source_byte inside {[8'h30:8'h39]};
        is_space  = source_byte inside {CH_SPACE, CH_TAB, CH_NL};
    end

    // Punctuation decode.
    always_comb
    begin
        case (source_byte)
            CH_COLON:  punct_kind = K_COLON;
            CH_SEMI:   punct_kind = K_SEMI;
            CH_EQ:     punct_kind = K_EQ;
            CH_PLUS:   punct_kind = K_PLUS;
            CH_MINUS:  punct_kind = K_MINUS;
            CH_LBRACE: punct_kind = K_LBRACE;
            CH_RBRACE: punct_kind = K_RBRACE;
            default:   punct_kind = K_UNKNOWN;
        endcase
    end

    // Kind of the pending word if it ended now.
    always_comb
    begin
        pending = (phase_reg == PH_ALPHA) || (phase_reg == PH_DIGIT);
        kw_done = (phase_reg == PH_ALPHA) &&
                  ((alive_reg[0] && len_reg == LEN_3) || (alive_reg[1] && len_reg == LEN_6));
        if (phase_reg == PH_ALPHA)
        begin
            if (alive_reg[0] && len_reg == LEN_3)
                word_kind = K_LET;
            else if (alive_reg[1] && len_reg == LEN_6)
                word_kind = K_RETURN;
            else
                word_kind = K_IDENT;
        end
        else if (alive_reg[2] && len_reg == LEN_3)
            word_kind = K_I32;
        else
            word_kind = began_reg ? K_IDENT : K_LITERAL;
        word_res = '{is_token: 1'b1, token_kind: word_kind, text_char: 8'h00,
                     word_overflow: ovf_reg};
    end

    // Word continuation: either keep the current word or start a fresh one.
    always_comb
    begin
        if (is_letter)
            cont = (phase_reg == PH_ALPHA);
        else
            cont = ((phase_reg == PH_ALPHA) && !kw_done) || (phase_reg == PH_DIGIT);
        b_len   = cont ? len_reg : '0;
        b_alive = cont ? alive_reg : 3'b111;
        b_ovf   = cont ? ovf_reg : 1'b0;
        b_began = cont ? began_reg : is_letter;
    end

    // Keyword tracking and length count for a word character.
    always_comb
    begin
        a_alive = 3'b000;
        if (!is_digit)
        begin
            a_alive[0] = b_alive[0] && (b_len < LEN_3) && (source_byte == let_char(b_len[2:0]));
            a_alive[1] = b_alive[1] && (b_len < LEN_6) &&
                         (source_byte == return_char(b_len[2:0]));
            a_alive[2] = b_alive[2] && (b_len == '0) && (source_byte == CH_I);
        end
        else
        begin
            a_alive[2] = b_alive[2] &&
                         (((b_len == LEN_W'(1)) && (source_byte == CH_THREE)) ||
                          ((b_len == LEN_W'(2)) && (source_byte == CH_TWO)));
        end
        if (b_len >= LEN_MAX)
        begin
            a_len = LEN_MAX;
            a_ovf = 1'b1;
        end
        else
        begin
            a_len = b_len + LEN_W'(1);
            a_ovf = b_ovf;
        end
    end

    // Result selection and next state.
    always_comb
    begin
        fin        = 1'b0;
        tail_valid = 1'b0;
        tail       = '0;
        phase_next = phase_reg;
        len_next   = len_reg;
        began_next = began_reg;
        alive_next = alive_reg;
        ovf_next   = ovf_reg;
        if (end_of_input)
        begin
            fin        = pending;
            tail_valid = 1'b1;
            tail       = '{is_token: 1'b1, token_kind: K_EOF, text_char: 8'h00,
                           word_overflow: 1'b0};
            phase_next = PH_IDLE;
            len_next   = '0;
            began_next = 1'b0;
            alive_next = 3'b111;
            ovf_next   = 1'b0;
        end
        else if (is_letter || is_digit)
        begin
            fin        = is_letter ? (phase_reg == PH_DIGIT) : kw_done;
            tail_valid = 1'b1;
            tail       = '{is_token: 1'b0, token_kind: K_EOF, text_char: source_byte,
                           word_overflow: a_ovf};
            phase_next = is_letter ? PH_ALPHA : PH_DIGIT;
            len_next   = a_len;
            began_next = b_began;
            alive_next = a_alive;
            ovf_next   = a_ovf;
        end
        else
        begin
            fin        = pending;
            tail_valid = !is_space;
            tail       = '{is_token: 1'b1, token_kind: punct_kind,
                           text_char: (punct_kind == K_UNKNOWN) ? source_byte : 8'h00,
                           word_overflow: 1'b0};
            phase_next = PH_IDLE;
            len_next   = '0;
            began_next = 1'b0;
            alive_next = 3'b111;
            ovf_next   = 1'b0;
        end
    end

    // Results handed to the queue for this transfer.
    always_comb
    begin
        push.count  = accept ? ({1'b0, fin} + {1'b0, tail_valid}) : 2'd0;
        push.first  = fin ? word_res : tail;
        push.second = tail;
    end

    // Word state registers, updated on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            began_reg <= 1'b0;
            alive_reg <= 3'b111;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            began_reg <= began_next;
            alive_reg <= alive_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef ASSERT_OFF
    // The spare phase code is never reached.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DIGIT)
        else $error("kwl_scan: spare phase code reached");

    // With no word pending the word state sits at its fresh values.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> (len_reg == '0 && alive_reg == 3'b111 && !ovf_reg))
        else $error("kwl_scan: idle phase with stale word state");

    // An overflowed word has a saturated length.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == LEN_MAX)
        else $error("kwl_scan: overflow flag without saturated length");
`endif

endmodule

// File: hw/rtl/kwl_queue.sv
// ----------------------------------------------------------------------------
// Lexer result queue
// Small register queue that takes up to two results a cycle from the scan
// stage and hands one per transfer to the token channel.
// ----------------------------------------------------------------------------
module kwl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  kwl_pkg::kwl_push_t  push,
    output logic                space,
    kwl_token_if.source         token_ch
);
    import kwl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kwl_result_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    kwl_result_t      head;

    // Room for two results keeps every byte acceptable in one transfer.
    assign space = count_reg <= CNT_W'(QUEUE_DEPTH - 2);

    // Head of the queue drives the token channel.
    assign head                   = mem_reg[rd_ptr_reg];
    assign token_ch.valid         = count_reg != '0;
    assign token_ch.is_token      = head.is_token;
    assign token_ch.token_kind    = head.token_kind;
    assign token_ch.text_char     = head.text_char;
    assign token_ch.word_overflow = head.word_overflow;
    assign pop                    = token_ch.valid && token_ch.ready;

    // Pointer and fill count arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    // The fill count never passes the depth.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("kwl_queue: fill count beyond depth");

    // Results only arrive while there is room for a full pair.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> space)
        else $error("kwl_queue: results pushed without room");

    // With no push and no pop the fill count holds.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("kwl_queue: fill count moved without traffic");

    // Pointers stay a fill count apart.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg))
        else $error("kwl_queue: pointers disagree with fill count");
`endif

endmodule

// File: dv/keyword_token_lexer_checker.sv
// ----------------------------------------------------------------------------
// Keyword token lexer checker
// Watches the byte and token channels of the lexer. It lexes every byte taken
// by the block with its own copy of the scan state, queues the results that
// byte should give, and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyword_token_lexer_checker #(
    parameter int MAX_WORD = kwl_pkg::MAX_WORD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    kwl_byte_if         byte_ch,
    kwl_token_if        token_ch,
    output int          error_count,
    output int          pending_count,
    output int          echo_count,
    output int          token_count,
    output int          overflow_count,
    output logic [13:0] kinds_seen
);

    import kwl_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_LETTERS,
        SCAN_DIGITS
    } scan_phase_e;

    // Keyword spellings, first character in the top byte.
    localparam logic [23:0] LET_TEXT    = "let";
    localparam logic [47:0] RETURN_TEXT = "return";

    // Scan state of the lexer as this checker sees it.
    scan_phase_e phase;
    logic [7:0]  word_len;
    logic        from_letter;
    logic [2:0]  kw_alive;
    logic        overflow;

    kwl_result_t expected_tokens[$];

    int          errors;
    int          echoes;
    int          tokens;
    int          overflows;
    logic [13:0] kinds;

    task automatic queue_result(input logic tok, input logic [3:0] kind,
                                input logic [7:0] ch, input logic ovf);
        kwl_result_t r;
        r.is_token      = tok;
        r.token_kind    = kind;
        r.text_char     = ch;
        r.word_overflow = ovf;
        expected_tokens.push_back(r);
    endtask

    task automatic open_word(input scan_phase_e next_phase, input logic letter);
        phase       = next_phase;
        word_len    = 8'd0;
        from_letter = letter;
        kw_alive    = 3'b111;
        overflow    = 1'b0;
    endtask

    // Emits the token of the pending word, if there is one, and returns to idle.
    task automatic close_word();
        logic [3:0] kind;
        if (phase == SCAN_LETTERS)
        begin
            if (kw_alive[0] && word_len == 8'd3)
                kind = K_LET;
            else if (kw_alive[1] && word_len == 8'd6)
                kind = K_RETURN;
            else
                kind = K_IDENT;
        end
        else if (phase == SCAN_DIGITS)
        begin
            if (kw_alive[2] && word_len == 8'd3)
                kind = K_I32;
            else
                kind = from_letter ? K_IDENT : K_LITERAL;
        end
        else
        begin
            phase = SCAN_IDLE;
            return;
        end
        queue_result(1'b1, kind, 8'h00, overflow);
        open_word(SCAN_IDLE, 1'b0);
    endtask

    // Adds one character to the word, narrowing the keyword candidates and
    // saturating the length counter.
    task automatic grow_word(input logic [7:0] c, input logic is_digit);
        int         p;
        logic [2:0] alive_next;
        p          = word_len;
        alive_next = 3'b000;
        if (!is_digit)
        begin
            if (kw_alive[0] && p < 3 && c == LET_TEXT[8*(2-p) +: 8])
                alive_next[0] = 1'b1;
            if (kw_alive[1] && p < 6 && c == RETURN_TEXT[8*(5-p) +: 8])
                alive_next[1] = 1'b1;
            if (kw_alive[2] && p == 0 && c == CH_I)
                alive_next[2] = 1'b1;
        end
        else if (kw_alive[2] && ((p == 1 && c == CH_THREE) || (p == 2 && c == CH_TWO)))
        begin
            alive_next[2] = 1'b1;
        end
        kw_alive = alive_next;
        if (p >= MAX_WORD)
        begin
            word_len = MAX_WORD[7:0];
            overflow = 1'b1;
        end
        else
        begin
            word_len = word_len + 8'd1;
        end
    endtask

    // Works out the results of one accepted byte or end mark.
    task automatic lex_byte(input logic [7:0] c, input logic mark);
        logic       is_letter;
        logic       is_digit;
        logic [3:0] kind;
        if (mark)
        begin
            close_word();
            queue_result(1'b1, K_EOF, 8'h00, 1'b0);
            return;
        end
        is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        is_digit  = (c >= "0" && c <= "9");
        if (is_letter)
        begin
            if (phase == SCAN_DIGITS)
                close_word();
            if (phase == SCAN_IDLE)
                open_word(SCAN_LETTERS, 1'b1);
            grow_word(c, 1'b0);
            queue_result(1'b0, K_EOF, c, overflow);
            return;
        end
        if (is_digit)
        begin
            // A complete let or return is a keyword even when a digit follows.
            if (phase == SCAN_LETTERS &&
                ((kw_alive[0] && word_len == 8'd3) || (kw_alive[1] && word_len == 8'd6)))
                close_word();
            if (phase == SCAN_IDLE)
                open_word(SCAN_DIGITS, 1'b0);
            else
                phase = SCAN_DIGITS;
            grow_word(c, 1'b1);
            queue_result(1'b0, K_EOF, c, overflow);
            return;
        end
        close_word();
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
            return;
        case (c)
            CH_COLON:  kind = K_COLON;
            CH_SEMI:   kind = K_SEMI;
            CH_EQ:     kind = K_EQ;
            CH_PLUS:   kind = K_PLUS;
            CH_MINUS:  kind = K_MINUS;
            CH_LBRACE: kind = K_LBRACE;
            CH_RBRACE: kind = K_RBRACE;
            default:   kind = K_UNKNOWN;
        endcase
        queue_result(1'b1, kind, (kind == K_UNKNOWN) ? c : 8'h00, 1'b0);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Compares one result transfer with the oldest expectation.
    task automatic check_result(input kwl_result_t got);
        kwl_result_t want;
        if (got.is_token)
        begin
            tokens++;
            kinds[got.token_kind] = 1'b1;
        end
        else
        begin
            echoes++;
        end
        if (got.word_overflow)
            overflows++;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual tok=%0b kind=%0d ch=%02h ovf=%0b",
                     $time, got.is_token, got.token_kind, got.text_char, got.word_overflow);
            return;
        end
        want = expected_tokens.pop_front();
        if (got.is_token !== want.is_token)
            report_field("is_token", want.is_token, got.is_token);
        if (got.token_kind !== want.token_kind)
            report_field("token_kind", want.token_kind, got.token_kind);
        if (got.text_char !== want.text_char)
            report_field("text_char", want.text_char, got.text_char);
        if (got.word_overflow !== want.word_overflow)
            report_field("word_overflow", want.word_overflow, got.word_overflow);
    endtask

    // Byte transfers are lexed before the result transfer of the same edge is checked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_word(SCAN_IDLE, 1'b0);
            expected_tokens.delete();
            errors    = 0;
            echoes    = 0;
            tokens    = 0;
            overflows = 0;
            kinds     = '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                lex_byte(byte_ch.source_byte, byte_ch.end_of_input);
            if (token_ch.valid && token_ch.ready)
                check_result({token_ch.is_token, token_ch.token_kind,
                              token_ch.text_char, token_ch.word_overflow});
        end
        error_count    <= errors;
        pending_count  <= expected_tokens.size();
        echo_count     <= echoes;
        token_count    <= tokens;
        overflow_count <= overflows;
        kinds_seen     <= kinds;
    end

endmodule

// File: dv/keyword_token_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// Keyword token lexer core testbench
// Feeds the lexer a short directed source text and then a long stream of
// random keywords, identifiers, literals, punctuation, overlong words, noise
// and end marks, with random gaps and stalls on both channels and one long
// stall of the token channel. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyword_token_lexer_core_tb;

    import kwl_pkg::*;

    localparam int MAX_WORD     = MAX_WORD_DEF;
    localparam int RANDOM_BYTES = 900;
    localparam int LONG_STALL   = 300;

    logic clk = 1'b0;
    logic rst_n;

    kwl_byte_if  byte_ch ();
    kwl_token_if token_ch ();

    int          error_count;
    int          pending_count;
    int          echo_count;
    int          token_count;
    int          overflow_count;
    logic [13:0] kinds_seen;

    // Pacing of both channels; mode 0 means no idling at all.
    int   src_mode;
    int   snk_mode;
    logic no_gaps;
    logic hold_sink;
    int   bytes_sent;
    int   marks_sent;

    keyword_token_lexer_core #(
        .MAX_WORD (MAX_WORD)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch)
    );

    keyword_token_lexer_checker #(
        .MAX_WORD (MAX_WORD)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_ch        (byte_ch),
        .token_ch       (token_ch),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .echo_count     (echo_count),
        .token_count    (token_count),
        .overflow_count (overflow_count),
        .kinds_seen     (kinds_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog for a hung run.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Token channel receiver: random stall before each transfer, plus one long
    // hold-off on request so that the result queue fills and the input stalls.
    initial
    begin
        int n;
        token_ch.ready = 1'b0;
        snk_mode       = 1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                token_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                hold_sink = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                snk_mode = $urandom_range(0, 2);
            n = (snk_mode == 0) ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
            do @(posedge clk); while (!token_ch.valid);
        end
    end

    // Offers one byte after a random gap and waits for its transfer.
    task automatic send_byte(input logic [7:0] c, input logic mark);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_mode = $urandom_range(0, 2);
        gap = (src_mode == 0 || no_gaps) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            byte_ch.valid        <= 1'b0;
            byte_ch.source_byte  <= 8'($urandom);
            byte_ch.end_of_input <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.source_byte  <= c;
        byte_ch.end_of_input <= mark;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
        if (mark)
            marks_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] offset;
        offset = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) != 0) ? 8'h61 + offset : 8'h41 + offset;
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 6))
            0:       return CH_COLON;
            1:       return CH_SEMI;
            2:       return CH_EQ;
            3:       return CH_PLUS;
            4:       return CH_MINUS;
            5:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    // Words one or two characters off a keyword, in spelling or in case.
    function automatic string pick_near_keyword();
        case ($urandom_range(0, 9))
            0:       return "le";
            1:       return "lets";
            2:       return "retur";
            3:       return "returns";
            4:       return "i3";
            5:       return "i321";
            6:       return "i32x";
            7:       return "I32";
            8:       return "Let";
            default: return "i";
        endcase
    endfunction

    // A word of the given length ended by a semicolon: letters with four trailing digits, or digits only.
    task automatic send_long_word(input int len, input logic digits_first);
        for (int i = 0; i < len; i++)
        begin
            if (digits_first)
                send_byte(pick_digit(), 1'b0);
            else
                send_byte((i < len - 4) ? pick_letter() : pick_digit(), 1'b0);
        end
        send_byte(CH_SEMI, 1'b0);
    endtask

    // One piece of source text: mostly well-formed words and punctuation,
    // sometimes noise bytes and end marks.
    task automatic send_piece();
        int n;
        case ($urandom_range(0, 15))
            0:  send_text("let");
            1:  send_text("return");
            2:  send_text("i32");
            3:
            begin
                if ($urandom_range(0, 1) != 0)
                    send_text("let");
                else
                    send_text("return");
                n = $urandom_range(1, 3);
                repeat (n) send_byte(pick_digit(), 1'b0);
            end
            4:  send_text(pick_near_keyword());
            5, 6:
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_byte(pick_letter(), 1'b0);
                n = $urandom_range(0, 3);
                repeat (n) send_byte(pick_digit(), 1'b0);
            end
            7:
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(pick_digit(), 1'b0);
            end
            8:
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(pick_digit(), 1'b0);
                n = $urandom_range(1, 3);
                repeat (n) send_byte(pick_letter(), 1'b0);
            end
            9, 10, 11: send_byte(pick_punct(), 1'b0);
            12: send_byte(8'($urandom_range(0, 255)), 1'b0);
            13: send_byte(8'($urandom_range(128, 255)), 1'b0);
            14: send_byte(8'($urandom_range(0, 255)), 1'b1);
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(pick_space(), 1'b0);
            end
        endcase
        if ($urandom_range(0, 1) != 0)
            send_byte(pick_space(), 1'b0);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int wait_cycles;
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.source_byte  = 8'h00;
        byte_ch.end_of_input = 1'b0;
        src_mode             = 1;
        no_gaps              = 1'b0;
        hold_sink            = 1'b0;
        bytes_sent           = 0;
        marks_sent           = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keywords followed by digits, i32, digits then a letter, a word ended
        // by the largest byte, all punctuation, whitespace, the zero byte, an
        // end mark with a word pending and one with nothing pending.
        send_text("let7:return1;i32=9x");
        send_byte(8'hFF, 1'b0);
        send_text("+-{}\t \n");
        send_byte(8'h00, 1'b0);
        send_text("a");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("z ");

        // Long hold-off on the token channel while bytes keep coming.
        hold_sink = 1'b1;
        no_gaps   = 1'b1;
        repeat (12) send_piece();
        no_gaps   = 1'b0;

        // Words at the length limit and one and four characters past it.
        send_long_word(MAX_WORD, 1'b0);
        send_long_word(MAX_WORD + 1, 1'b0);
        send_long_word(MAX_WORD + 4, 1'b1);

        // Random text until the whole run has offered about the planned bytes.
        while (bytes_sent < RANDOM_BYTES)
            send_piece();
        byte_ch.valid <= 1'b0;

        // Drain, then watch a little longer for stray results.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        wait_cycles = 30;
        repeat (wait_cycles) @(posedge clk);

        $display("Sent %0d source bytes including %0d end marks; checked %0d echoes and %0d tokens.",
                 bytes_sent, marks_sent, echo_count, token_count);
        $display("Token kinds seen: %0d of 14; results flagged as overlong: %0d.",
                 $countones(kinds_seen), overflow_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
